@@ rtl/rsas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared widths, command codes and sequencer states of the rotated sorted
// array search core.
// ----------------------------------------------------------------------------
package rsas_pkg;

    // word field widths
    localparam int CMD_W = 1;
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int LEN_W = 11;
    localparam int POS_W = 10;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

    // search sequencer
    typedef enum logic [2:0] {
        S_IDLE,   // accept words
        S_MID,    // range check, read middle entry
        S_VM,     // middle entry back, compare, read upper bound
        S_VH,     // upper bound back, maybe read lower bound
        S_VL,     // lower bound back, narrow range
        S_DONE    // result word waits for the receiver
    } t_state;

endpackage

@@ rtl/rsas_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_in_if
// Input word channel: store write or search command.
// ----------------------------------------------------------------------------
interface rsas_in_if;
    logic                         valid;
    logic                         ready;
    logic [rsas_pkg::CMD_W-1:0]   command;
    logic [rsas_pkg::IDX_W-1:0]   index;
    logic signed [rsas_pkg::VAL_W-1:0] value;

    modport source (output valid, command, index, value, input ready);
    modport sink   (input valid, command, index, value, output ready);
endinterface

@@ rtl/rsas_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_out_if
// Result word channel: found flag and entry position.
// ----------------------------------------------------------------------------
interface rsas_out_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [rsas_pkg::POS_W-1:0] position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

@@ rtl/rsas_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_cfg_if
// Configuration write channel carrying the search length register.
// ----------------------------------------------------------------------------
interface rsas_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rsas_pkg::LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/rotated_sorted_array_search_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_core
// Binary search for a target in a rotated ascending store, one probe at a
// time over a memory with one read port.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : writes the length register (entries 0..length-1 are searched,
//            clipped to DEPTH). Always ready; write only while idle.
//   i_in   : a word with command CMD_WRITE stores value at index (index at or
//            beyond DEPTH is dropped) and gives no result.
//            A word with command CMD_SEARCH looks up value and gives one
//            result word on o_out (found, position; position 0 if absent).
//   Search:  a search makes at most floor(log2(n))+1 probes; each probe
//            reads the middle entry and, unless it hits, the upper and
//            sometimes the lower entry through the one memory read port;
//            a final range check ends a miss. The result is shown the
//            cycle after the last step.
//   i_in is not ready while a search runs or a result waits; a stalled
//   receiver holds the result word steady until taken.
//   Reset clears the sequencer and the length register; store contents stay
//   undefined until written.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_core #(
    parameter int DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsas_cfg_if.sink    i_cfg,
    rsas_in_if.sink     i_in,
    rsas_out_if.source  o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // store address
    localparam int NW = $clog2(DEPTH + 1);                  // holds DEPTH
    localparam int CW = NW + 1;                             // signed bound

    typedef logic signed [CW-1:0] t_bound;

    // registers
    rsas_pkg::t_state                    r_state, n_state;
    logic [rsas_pkg::LEN_W-1:0]          r_length;
    logic signed [rsas_pkg::VAL_W-1:0]   r_mem [DEPTH];
    logic signed [rsas_pkg::VAL_W-1:0]   r_rdata;
    logic signed [rsas_pkg::VAL_W-1:0]   r_target, n_target;
    logic signed [rsas_pkg::VAL_W-1:0]   r_vm, n_vm;
    t_bound                              r_lo, n_lo;
    t_bound                              r_hi, n_hi;
    t_bound                              r_mid, n_mid;
    logic                                r_found, n_found;
    logic [rsas_pkg::POS_W-1:0]          r_pos, n_pos;

    // combinational helpers
    logic                                w_in_acc;
    logic                                w_wr_en;
    logic [AW-1:0]                       w_rd_addr;
    t_bound                              w_n;
    t_bound                              w_mid;
    logic                                w_empty;
    logic                                w_hit;
    logic                                w_upper_sorted;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_wr_en  = w_in_acc && (i_in.command == rsas_pkg::CMD_WRITE)
                      && (32'(i_in.index) < 32'(DEPTH));

    // covered entry count, clipped to the store depth
    assign w_n = (32'(r_length) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(r_length);

    // probe arithmetic
    assign w_empty        = r_lo > r_hi;
    assign w_mid          = r_lo + ((r_hi - r_lo) >>> 1);
    assign w_hit          = r_rdata == r_target;
    assign w_upper_sorted = r_vm < r_rdata;

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[AW'(i_in.index)] <= i_in.value;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_length <= i_cfg.data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsas_pkg::S_IDLE: begin
                if (w_in_acc && (i_in.command == rsas_pkg::CMD_SEARCH)) begin
                    n_state = rsas_pkg::S_MID;
                end
            end
            rsas_pkg::S_MID: begin
                n_state = w_empty ? rsas_pkg::S_DONE : rsas_pkg::S_VM;
            end
            rsas_pkg::S_VM: begin
                n_state = w_hit ? rsas_pkg::S_DONE : rsas_pkg::S_VH;
            end
            rsas_pkg::S_VH: begin
                n_state = w_upper_sorted ? rsas_pkg::S_MID : rsas_pkg::S_VL;
            end
            rsas_pkg::S_VL: begin
                n_state = rsas_pkg::S_MID;
            end
            rsas_pkg::S_DONE: begin
                if (o_out.ready) begin
                    n_state = rsas_pkg::S_IDLE;
                end
            end
            default: n_state = rsas_pkg::S_IDLE;
        endcase
    end

    // outputs, read address and datapath updates
    always_comb begin
        i_in.ready  = (r_state == rsas_pkg::S_IDLE);
        i_cfg.ready = 1'b1;
        o_out.valid = (r_state == rsas_pkg::S_DONE);

        w_rd_addr = AW'($unsigned(r_mid));
        n_target  = r_target;
        n_vm      = r_vm;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_found   = r_found;
        n_pos     = r_pos;

        unique case (r_state)
            rsas_pkg::S_IDLE: begin
                n_target = i_in.value;
                n_lo     = '0;
                n_hi     = w_n - t_bound'(1);
            end
            rsas_pkg::S_MID: begin
                // read middle entry; empty range ends the search
                w_rd_addr = AW'($unsigned(w_mid));
                n_mid     = w_mid;
                if (w_empty) begin
                    n_found = 1'b0;
                    n_pos   = '0;
                end
            end
            rsas_pkg::S_VM: begin
                // middle entry arrives; read upper bound next
                w_rd_addr = AW'($unsigned(r_hi));
                n_vm      = r_rdata;
                if (w_hit) begin
                    n_found = 1'b1;
                    n_pos   = rsas_pkg::POS_W'($unsigned(r_mid));
                end
            end
            rsas_pkg::S_VH: begin
                // upper bound arrives; upper half sorted decides here
                w_rd_addr = AW'($unsigned(r_lo));
                if (w_upper_sorted) begin
                    if ((r_target > r_vm) && (r_target <= r_rdata)) begin
                        n_lo = r_mid + t_bound'(1);
                    end else begin
                        n_hi = r_mid - t_bound'(1);
                    end
                end
            end
            rsas_pkg::S_VL: begin
                // lower bound arrives; lower half is the sorted one
                if ((r_target < r_vm) && (r_target >= r_rdata)) begin
                    n_hi = r_mid - t_bound'(1);
                end else begin
                    n_lo = r_mid + t_bound'(1);
                end
            end
            rsas_pkg::S_DONE: begin
                w_rd_addr = AW'($unsigned(r_mid));
            end
            default: begin
                w_rd_addr = AW'($unsigned(r_mid));
            end
        endcase

        o_out.found    = r_found;
        o_out.position = r_pos;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsas_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_target <= n_target;
        r_vm     <= n_vm;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_found  <= n_found;
        r_pos    <= n_pos;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // no new word is taken while a result is pending
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while result pending");

    // a miss always reports position zero
    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.position == '0))
        else $error("miss with nonzero position");

    // a store write never produces a result word
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.command == rsas_pkg::CMD_WRITE)) |=> !o_out.valid)
        else $error("result after store write");

    // lower bound never goes negative during a search
    a_lo_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsas_pkg::S_MID) |-> !r_lo[CW-1])
        else $error("negative lower bound");

endmodule

@@ sim/rsas_search_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsas_search_checker
// Watches the config, input and result channels of the rotated sorted array
// search core. It mirrors the store and the length register, works out the
// answer of every accepted search and compares each result word with the
// oldest answer still due.
// ----------------------------------------------------------------------------
module rsas_search_checker #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rsas_cfg_if  i_cfg,
    rsas_in_if   i_in,
    rsas_out_if  i_out,
    output int   o_mismatches,
    output int   o_pending
);

    typedef struct packed {
        logic                       found;
        logic [rsas_pkg::POS_W-1:0] position;
    } t_lookup;

    logic signed [rsas_pkg::VAL_W-1:0] mirror [STORE_DEPTH];
    logic [rsas_pkg::LEN_W-1:0]        search_len;
    t_lookup                           answers_due[$];
    int                                mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // probe loop over the mirrored store; range clipped to the store depth
    function automatic t_lookup locate_target(
        input logic signed [rsas_pkg::VAL_W-1:0] target
    );
        int                                lo;
        int                                hi;
        int                                mid;
        logic signed [rsas_pkg::VAL_W-1:0] mid_val;
        logic signed [rsas_pkg::VAL_W-1:0] hi_val;
        logic signed [rsas_pkg::VAL_W-1:0] lo_val;
        t_lookup                           res;
        res = '{found: 1'b0, position: '0};
        lo  = 0;
        hi  = (int'(search_len) > STORE_DEPTH) ? STORE_DEPTH - 1 : int'(search_len) - 1;
        while (lo <= hi) begin
            mid     = lo + (hi - lo) / 2;
            mid_val = mirror[mid];
            if (mid_val == target) begin
                res.found    = 1'b1;
                res.position = rsas_pkg::POS_W'(mid);
                return res;
            end
            hi_val = mirror[hi];
            if (mid_val < hi_val) begin
                // upper half is in order
                if (target > mid_val && target <= hi_val) lo = mid + 1;
                else hi = mid - 1;
            end else begin
                // lower half is in order
                lo_val = mirror[lo];
                if (target < mid_val && target >= lo_val) hi = mid - 1;
                else lo = mid + 1;
            end
        end
        return res;
    endfunction

    // all channels sampled at the edge, before the block updates
    always @(posedge i_clk) begin
        t_lookup due;
        if (!i_rst_n) begin
            search_len = '0;
            answers_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                search_len = i_cfg.data;

            if (i_in.valid && i_in.ready) begin
                if (i_in.command == rsas_pkg::CMD_WRITE)
                    mirror[i_in.index] = i_in.value;
                else
                    answers_due.push_back(locate_target(i_in.value));
            end

            if (i_out.valid && i_out.ready) begin
                if (answers_due.size() == 0) begin
                    $error("result word with no search pending: found %0b position %0d",
                           i_out.found, i_out.position);
                    mismatch_count++;
                end else begin
                    due = answers_due.pop_front();
                    if (i_out.found !== due.found) begin
                        $error("found: expected %0b, actual %0b", due.found, i_out.found);
                        mismatch_count++;
                    end
                    if (i_out.position !== due.position) begin
                        $error("position: expected %0d, actual %0d",
                               due.position, i_out.position);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

@@ sim/rotated_sorted_array_search_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_core_tb
// Drives store writes, length settings and searches into the search core and
// pulls its result words under varying backpressure. A directed opener hits
// the empty range, the signed extremes and a one-entry range; then the low
// part of the store is loaded and searched, and the full and over-long
// lengths are tried on a target sitting in the middle entry; then random
// phases load short rotated, scrambled or repeating data and search it.
// Checking is done by rsas_search_checker.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_core_tb;

    localparam int STORE_DEPTH   = 1024;
    localparam int PRELOAD_WORDS = 256;
    localparam int RANDOM_WORDS  = 220;

    // value parked in the middle entry of the full range
    localparam logic signed [rsas_pkg::VAL_W-1:0] MID_VALUE = 32'sd123456789;

    typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} t_pace;
    typedef enum int {DATA_ROTATED, DATA_SCRAMBLED, DATA_REPEATS} t_data_kind;

    logic i_clk;
    logic i_rst_n;

    rsas_cfg_if cfg_if ();
    rsas_in_if  in_if ();
    rsas_out_if out_if ();

    int src_gap_pct;
    int sink_stall_pct;
    int words_sent;
    int mismatches;
    int pending;

    // data image of the current phase, before it is written
    logic signed [rsas_pkg::VAL_W-1:0] load_buf [STORE_DEPTH];

    rotated_sorted_array_search_core #(
        .DEPTH (STORE_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rsas_search_checker #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_if),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // result receiver stalls at random
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    initial begin
        #(20_000_000);
        $display("rotated_sorted_array_search_core test failed");
        $finish;
    end

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_SLOW_SINK: begin
                src_gap_pct    = 15;
                sink_stall_pct = 85;
            end
            PACE_SLOW_SOURCE: begin
                src_gap_pct    = 85;
                sink_stall_pct = 15;
            end
            default: begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    // one input word; returns at the edge that takes it
    task automatic send_word(input logic [rsas_pkg::CMD_W-1:0] cmd,
                             input logic [rsas_pkg::IDX_W-1:0] idx,
                             input logic signed [rsas_pkg::VAL_W-1:0] val);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.command <= cmd;
        in_if.index   <= idx;
        in_if.value   <= val;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // hold the sender until every search has answered and the block settles
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_search_length(input logic [rsas_pkg::LEN_W-1:0] len);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= len;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // fill load_buf[0..count-1] with data of the given kind
    task automatic build_image(input t_data_kind kind, input int count);
        longint                            acc;
        longint                            step_max;
        int                                pivot;
        logic signed [rsas_pkg::VAL_W-1:0] ladder [STORE_DEPTH];
        if (count == 0) return;
        case (kind)
            DATA_REPEATS: begin
                for (int i = 0; i < count; i++)
                    load_buf[i] = $signed(rsas_pkg::VAL_W'($urandom_range(0, 6))) - 3;
            end
            DATA_SCRAMBLED: begin
                for (int i = 0; i < count; i++)
                    load_buf[i] = $urandom();
            end
            default: begin
                // ascending distinct values, either tightly packed or spread
                if ($urandom_range(0, 3) == 0) begin
                    step_max = 3;
                    acc      = longint'($signed($urandom()));
                    if (acc > 64'sd2147483647 - 3 * count) acc -= 4 * count;
                end else begin
                    step_max = (64'sd4294967295 - 64'sd1048576) / count;
                    acc      = -64'sd2147483648 + $urandom_range(0, 1048576);
                end
                for (int i = 0; i < count; i++) begin
                    ladder[i] = acc[rsas_pkg::VAL_W-1:0];
                    acc += $urandom_range(1, 32'(step_max));
                end
                pivot = $urandom_range(0, count - 1);
                for (int i = 0; i < count; i++)
                    load_buf[i] = ladder[(i + pivot) % count];
            end
        endcase
    endtask

    task automatic load_image(input int count);
        for (int i = 0; i < count; i++)
            send_word(rsas_pkg::CMD_WRITE, rsas_pkg::IDX_W'(i), load_buf[i]);
    endtask

    // mostly values that are present, some neighbors, extremes and noise
    function automatic logic signed [rsas_pkg::VAL_W-1:0] pick_target(input int count);
        int roll;
        roll = $urandom_range(0, 99);
        if (count > 0 && roll < 60)
            return load_buf[$urandom_range(0, count - 1)];
        if (count > 0 && roll < 75)
            return load_buf[$urandom_range(0, count - 1)] + (roll[0] ? 1 : -1);
        if (roll < 85)
            return roll[0] ? 32'sh7FFFFFFF : 32'sh80000000;
        return $urandom();
    endfunction

    initial begin
        int                         random_start;
        int                         span;
        int                         loaded;
        int                         roll;
        t_data_kind                 kind;
        logic [rsas_pkg::LEN_W-1:0] new_len;

        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.command <= rsas_pkg::CMD_WRITE;
        in_if.index   <= '0;
        in_if.value   <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        words_sent     = 0;
        set_pace(PACE_SLOW_SINK);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // length still zero after reset: nothing can be found
        send_word(rsas_pkg::CMD_SEARCH, '0, 32'sd0);
        send_word(rsas_pkg::CMD_SEARCH, 10'h3FF, 32'sh80000000);

        // five entries rotated across the signed extremes
        send_word(rsas_pkg::CMD_WRITE, 10'd0, 32'sd10);
        send_word(rsas_pkg::CMD_WRITE, 10'd1, 32'sh7FFFFFFF);
        send_word(rsas_pkg::CMD_WRITE, 10'd2, 32'sh80000000);
        send_word(rsas_pkg::CMD_WRITE, 10'd3, -32'sd5);
        send_word(rsas_pkg::CMD_WRITE, 10'd4, 32'sd3);
        send_word(rsas_pkg::CMD_WRITE, 10'h3FF, 32'sd7);
        wait_idle();
        set_search_length(rsas_pkg::LEN_W'(5));
        send_word(rsas_pkg::CMD_SEARCH, 10'h155, 32'sd10);
        send_word(rsas_pkg::CMD_SEARCH, 10'h2AA, 32'sh7FFFFFFF);
        send_word(rsas_pkg::CMD_SEARCH, 10'h000, 32'sh80000000);
        send_word(rsas_pkg::CMD_SEARCH, 10'h3FF, -32'sd5);
        send_word(rsas_pkg::CMD_SEARCH, 10'h001, 32'sd3);
        send_word(rsas_pkg::CMD_SEARCH, 10'h000, 32'sd0);
        send_word(rsas_pkg::CMD_SEARCH, 10'h000, 32'sd11);
        send_word(rsas_pkg::CMD_SEARCH, 10'h000, 32'sh7FFFFFFE);

        // single-entry range
        wait_idle();
        set_search_length(rsas_pkg::LEN_W'(1));
        send_word(rsas_pkg::CMD_SEARCH, 10'h000, 32'sd10);
        send_word(rsas_pkg::CMD_SEARCH, 10'h000, -32'sd5);

        // low part of the store, searched over its whole range
        wait_idle();
        build_image(DATA_ROTATED, PRELOAD_WORDS);
        load_image(PRELOAD_WORDS);
        wait_idle();
        set_search_length(rsas_pkg::LEN_W'(PRELOAD_WORDS));
        repeat (30) send_word(rsas_pkg::CMD_SEARCH, rsas_pkg::IDX_W'($urandom()),
                              pick_target(PRELOAD_WORDS));

        // full and over-long lengths: the target sits in the first probed
        // entry, so the search never reaches unloaded entries
        send_word(rsas_pkg::CMD_WRITE, rsas_pkg::IDX_W'(STORE_DEPTH / 2 - 1), MID_VALUE);
        wait_idle();
        set_search_length(rsas_pkg::LEN_W'(STORE_DEPTH));
        repeat (2) send_word(rsas_pkg::CMD_SEARCH, rsas_pkg::IDX_W'($urandom()), MID_VALUE);
        wait_idle();
        set_search_length(rsas_pkg::LEN_W'(STORE_DEPTH + 1));
        repeat (2) send_word(rsas_pkg::CMD_SEARCH, rsas_pkg::IDX_W'($urandom()), MID_VALUE);
        wait_idle();
        set_search_length('1);
        repeat (2) send_word(rsas_pkg::CMD_SEARCH, rsas_pkg::IDX_W'($urandom()), MID_VALUE);

        // random phases: new length, new data, a handful of searches
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            span = words_sent - random_start;
            if (span < RANDOM_WORDS / 3) set_pace(PACE_SLOW_SINK);
            else if (span < 2 * RANDOM_WORDS / 3) set_pace(PACE_SLOW_SOURCE);
            else set_pace(PACE_FULL);
            wait_idle();

            roll = $urandom_range(0, 99);
            if (roll < 5) new_len = '0;
            else if (roll < 60) new_len = rsas_pkg::LEN_W'($urandom_range(1, 16));
            else if (roll < 85) new_len = rsas_pkg::LEN_W'($urandom_range(17, 64));
            else if (roll < 92) new_len = rsas_pkg::LEN_W'($urandom_range(65, 200));
            else new_len = rsas_pkg::LEN_W'($urandom_range(33, PRELOAD_WORDS));
            // long random lengths reuse what earlier phases left in the store
            loaded = (roll >= 92) ? 32 : int'(new_len);
            set_search_length(new_len);

            roll = $urandom_range(0, 99);
            kind = (roll < 75) ? DATA_ROTATED : (roll < 90) ? DATA_SCRAMBLED : DATA_REPEATS;
            build_image(kind, loaded);
            load_image(loaded);

            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 5) == 0)
                    send_word(rsas_pkg::CMD_WRITE, rsas_pkg::IDX_W'($urandom()), $urandom());
                if ($urandom_range(0, 19) == 0)
                    wait_idle();
                send_word(rsas_pkg::CMD_SEARCH, rsas_pkg::IDX_W'($urandom()),
                          pick_target(loaded));
            end
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("rotated_sorted_array_search_core test passed");
        else
            $display("rotated_sorted_array_search_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rsas_pkg.sv
rtl/rsas_in_if.sv
rtl/rsas_out_if.sv
rtl/rsas_cfg_if.sv
rtl/rotated_sorted_array_search_core.sv
sim/rsas_search_checker.sv
sim/rotated_sorted_array_search_core_tb.sv
